// ----- sv/drum_step_sequencer_assert.svh -----
// Assertion macros for the step sequencer.
`ifndef DRUM_STEP_SEQUENCER_ASSERT_SVH
`define DRUM_STEP_SEQUENCER_ASSERT_SVH
`define DSS_ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define DSS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("reset assertion failed");
`endif

// ----- sv/dss_pkg.sv -----
`timescale 1ns / 1ps
package dss_pkg;
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_RECORD  = 3'd1;
  localparam logic [2:0] KIND_DELETE  = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_PENDING = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] REG_PLAY   = 3'd0;
  localparam logic [2:0] REG_REC    = 3'd1;
  localparam logic [2:0] REG_BARS   = 3'd2;
  localparam logic [2:0] REG_STEPS  = 3'd3;
  localparam logic [2:0] REG_MERGE  = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] sound;
    logic [2:0] bar_sel;
    logic [5:0] step_sel;
  } cmd_t;

  typedef struct packed {
    logic [15:0] trigger_mask;
    logic [2:0]  played_bar;
    logic [5:0]  played_step;
    logic        changed;
    logic [1:0]  status;
  } res_t;
endpackage

// ----- sv/dss_ram.sv -----
`timescale 1ns / 1ps
module dss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/dss_front.sv -----
`timescale 1ns / 1ps
module dss_front #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dss_pkg::cmd_t  in_cmd_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output dss_pkg::cmd_t  cmd_o
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  dss_pkg::cmd_t fifo_q [Depth];
  logic [AW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != (AW+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = cmd_valid_o & cmd_ready_i;

  always_comb begin
    rd_d = rd_q;
    wr_d = wr_q;
    if (pop)  rd_d = (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
    if (push) wr_d = (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      cnt_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ----- sv/dss_back.sv -----
`timescale 1ns / 1ps
module dss_back #(
  parameter int Sounds = 16,
  parameter int Bars = 8,
  parameter int Steps = 64,
  parameter int QueueDepth = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  dss_pkg::cmd_t cmd_i,
  input  logic          play_en_i,
  input  logic          rec_en_i,
  input  logic [3:0]    bar_count_i,
  input  logic [6:0]    steps_per_bar_i,
  input  logic [6:0]    merge_interval_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output dss_pkg::res_t res_o
);
  localparam int SW = (Sounds > 1) ? $clog2(Sounds) : 1;
  localparam int BW = (Bars > 1) ? $clog2(Bars) : 1;
  localparam int TW = $clog2(Steps);
  localparam int RD = Bars * Sounds;
  localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QEW = SW + BW + TW;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_WAIT = 4'd2, S_EXEC = 4'd3,
    S_CLR_RD = 4'd4, S_CLR_WAIT = 4'd5, S_CLR_WR = 4'd6, S_MQ_RD = 4'd7,
    S_MQ_WAIT = 4'd8, S_MR_WAIT = 4'd9, S_MR_WR = 4'd10, S_OUT = 4'd11;

  logic [3:0] st_q, st_d;
  dss_pkg::cmd_t cmd_q;
  dss_pkg::res_t res_q, res_d;
  logic [TW-1:0] pstep_q, pstep_d;
  logic [BW-1:0] pbar_q, pbar_d;
  logic [QW:0] pcnt_q, pcnt_d;
  logic [QW:0] qi_q, qi_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [6:0] mod_q, mod_d;
  logic [BW:0] cb_q, cb_d;
  logic [QEW-1:0] qe_q, qe_d;
  logic [31:0] mask_q, mask_d;

  logic pwe; logic [RAW-1:0] pwa, pra; logic [Steps-1:0] pwd, prd;
  logic qwe; logic [QW-1:0] qwa, qra; logic [QEW-1:0] qwd, qrd;
  logic [RD-1:0] rv_q, rv_d;
  logic [Steps-1:0] row;

  dss_ram #(.Width(Steps), .Depth(RD)) u_pat (
    .clk_i, .we_i(pwe), .waddr_i(pwa), .wdata_i(pwd), .raddr_i(pra), .rdata_o(prd));
  dss_ram #(.Width(QEW), .Depth(QueueDepth)) u_q (
    .clk_i, .we_i(qwe), .waddr_i(qwa), .wdata_i(qwd), .raddr_i(qra), .rdata_o(qrd));

  logic [4:0] effb; logic [7:0] effs; logic [6:0] ivl;
  always_comb begin
    effb = (bar_count_i == 0) ? 5'd1 :
           ({1'b0, bar_count_i} > 5'(Bars)) ? 5'(Bars) : {1'b0, bar_count_i};
    effs = (steps_per_bar_i == 0) ? 8'd1 :
           ({1'b0, steps_per_bar_i} > 8'(Steps)) ? 8'(Steps) : {1'b0, steps_per_bar_i};
    ivl = (merge_interval_i == 0) ? 7'd1 : merge_interval_i;
  end

  function automatic logic fits(input logic [3:0] s, input logic [2:0] b,
                                input logic [5:0] t, input logic [4:0] eb,
                                input logic [7:0] es);
    fits = (32'(s) < Sounds) && ({2'b0, b} < eb) && ({2'b0, t} < es);
  endfunction

  function automatic logic [RAW-1:0] raddr(input logic [BW-1:0] b,
                                           input logic [SW-1:0] s);
    raddr = RAW'(b * Sounds + s);
  endfunction

  assign row = rv_q[pra] ? prd : '0;
  assign cmd_ready_o = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_OUT);
  assign res_o = res_q;

  logic [SW-1:0] qs; logic [BW-1:0] qb; logic [TW-1:0] qt;
  assign {qs, qb, qt} = qe_q;

  always_comb begin
    logic [TW:0] ns;
    logic [BW:0] nb;
    logic [Steps-1:0] m;
    st_d = st_q; res_d = res_q; pstep_d = pstep_q; pbar_d = pbar_q;
    pcnt_d = pcnt_q; qi_d = qi_q; idx_d = idx_q; mod_d = mod_q; cb_d = cb_q;
    qe_d = qe_q; mask_d = mask_q; rv_d = rv_q;
    ns = '0; nb = '0; m = '0;
    pwe = 1'b0; pwa = raddr(pbar_q, idx_q); pwd = '0; pra = pwa;
    qwe = 1'b0; qwa = pcnt_q[QW-1:0]; qwd = '0; qra = qi_q[QW-1:0];
    unique case (st_q)
      S_IDLE: if (cmd_valid_i) begin
        res_d = '0; idx_d = '0; mask_d = '0;
        st_d = S_EXEC;
        unique case (cmd_i.kind)
          dss_pkg::KIND_TICK:
            if (!play_en_i) res_d.status = dss_pkg::ST_IGNORED;
            else st_d = S_RD;
          dss_pkg::KIND_RECORD:
            if (!rec_en_i) res_d.status = dss_pkg::ST_IGNORED;
            else if (!fits(cmd_i.sound, 3'(pbar_q), 6'(pstep_q), effb, effs))
              res_d.status = dss_pkg::ST_BAD;
            else st_d = S_RD;
          dss_pkg::KIND_DELETE:
            if (!fits(cmd_i.sound, cmd_i.bar_sel, cmd_i.step_sel, effb, effs))
              res_d.status = dss_pkg::ST_BAD;
            else st_d = S_RD;
          dss_pkg::KIND_CLEAR:
            if (32'(cmd_i.sound) >= Sounds) res_d.status = dss_pkg::ST_BAD;
            else begin cb_d = '0; st_d = S_CLR_RD; end
          dss_pkg::KIND_PENDING:
            if (!fits(cmd_i.sound, cmd_i.bar_sel, cmd_i.step_sel, effb, effs))
              res_d.status = dss_pkg::ST_BAD;
            else if (pcnt_q >= (QW+1)'(QueueDepth)) res_d.status = dss_pkg::ST_FULL;
            else begin
              qwe = 1'b1;
              qwd = {SW'(cmd_i.sound), BW'(cmd_i.bar_sel), TW'(cmd_i.step_sel)};
              pcnt_d = pcnt_q + 1'b1;
            end
          default: res_d.status = dss_pkg::ST_BAD;
        endcase
        if (st_d == S_EXEC) st_d = S_OUT;
      end
      S_RD: begin
        unique case (cmd_q.kind)
          dss_pkg::KIND_TICK:   pra = raddr(pbar_q, idx_q);
          dss_pkg::KIND_RECORD: pra = raddr(pbar_q, SW'(cmd_q.sound));
          default:              pra = raddr(BW'(cmd_q.bar_sel), SW'(cmd_q.sound));
        endcase
        st_d = S_WAIT;
      end
      S_WAIT: begin
        unique case (cmd_q.kind)
          dss_pkg::KIND_TICK:   pra = raddr(pbar_q, idx_q);
          dss_pkg::KIND_RECORD: pra = raddr(pbar_q, SW'(cmd_q.sound));
          default:              pra = raddr(BW'(cmd_q.bar_sel), SW'(cmd_q.sound));
        endcase
        st_d = S_EXEC;
        unique case (cmd_q.kind)
          dss_pkg::KIND_TICK: begin
            mask_d[idx_q] = row[pstep_q];
            if (32'(idx_q) == Sounds - 1) begin
              res_d.trigger_mask = 16'(mask_d);
              res_d.played_bar = 3'(pbar_q);
              res_d.played_step = 6'(pstep_q);
              ns = {1'b0, pstep_q} + 1'b1;
              if (8'(ns) >= effs) begin
                ns = '0;
                nb = {1'b0, pbar_q} + 1'b1;
                pbar_d = (5'(nb) >= effb) ? '0 : nb[BW-1:0];
              end
              pstep_d = ns[TW-1:0];
              mod_d = 7'(ns);
              st_d = S_EXEC;
            end else begin
              idx_d = idx_q + 1'b1;
              st_d = S_RD;
            end
          end
          dss_pkg::KIND_RECORD: begin
            pwe = 1'b1; pwa = pra;
            pwd = row | (Steps'(1) << pstep_q);
            rv_d[pra] = 1'b1;
            res_d.trigger_mask = 16'(32'(1) << cmd_q.sound);
            res_d.played_bar = 3'(pbar_q);
            res_d.played_step = 6'(pstep_q);
            st_d = S_OUT;
          end
          default: begin
            m = Steps'(1) << cmd_q.step_sel;
            pwe = 1'b1; pwa = pra;
            pwd = row & ~m;
            rv_d[pra] = 1'b1;
            res_d.changed = |(row & m);
            st_d = S_OUT;
          end
        endcase
      end
      S_EXEC: begin
        // Modulo by repeated subtraction of the merge interval.
        if (mod_q >= ivl) mod_d = mod_q - ivl;
        else if (mod_q == 0) begin qi_d = '0; st_d = S_MQ_RD; end
        else st_d = S_OUT;
      end
      S_MQ_RD: begin
        if (qi_q >= pcnt_q) begin pcnt_d = '0; st_d = S_OUT; end
        else st_d = S_MQ_WAIT;
      end
      S_MQ_WAIT: begin
        qe_d = qrd;
        qi_d = qi_q + 1'b1;
        if (fits(4'(qrd[QEW-1 -: SW]), 3'(qrd[TW +: BW]), 6'(qrd[TW-1:0]), effb, effs))
          st_d = S_MR_WAIT;
        else st_d = S_MQ_RD;
        pra = raddr(qrd[TW +: BW], qrd[QEW-1 -: SW]);
      end
      S_MR_WAIT: begin
        pra = raddr(qb, qs);
        st_d = S_MR_WR;
      end
      S_MR_WR: begin
        pra = raddr(qb, qs);
        m = Steps'(1) << qt;
        if (!(|(row & m))) begin
          pwe = 1'b1; pwa = pra; pwd = row | m; rv_d[pra] = 1'b1;
          res_d.changed = 1'b1;
        end
        st_d = S_MQ_RD;
      end
      S_CLR_RD: begin
        pra = raddr(cb_q[BW-1:0], SW'(cmd_q.sound));
        st_d = S_CLR_WAIT;
      end
      S_CLR_WAIT: begin
        pra = raddr(cb_q[BW-1:0], SW'(cmd_q.sound));
        st_d = S_CLR_WR;
      end
      S_CLR_WR: begin
        pra = raddr(cb_q[BW-1:0], SW'(cmd_q.sound));
        m = (effs >= 8'(Steps)) ? '1 : ((Steps'(1) << effs[TW-1:0]) - 1'b1);
        if (|(row & m)) res_d.changed = 1'b1;
        pwe = 1'b1; pwa = pra; pwd = row & ~m; rv_d[pra] = 1'b1;
        cb_d = cb_q + 1'b1;
        st_d = (5'(cb_d) >= effb) ? S_OUT : S_CLR_RD;
      end
      S_OUT: if (res_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    res_q <= res_d; idx_q <= idx_d; mod_q <= mod_d; cb_q <= cb_d;
    qe_q <= qe_d; mask_q <= mask_d; qi_q <= qi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pstep_q <= '0; pbar_q <= '0; pcnt_q <= '0; rv_q <= '0;
    end else begin
      st_q <= st_d; pstep_q <= pstep_d; pbar_q <= pbar_d; pcnt_q <= pcnt_d;
      rv_q <= rv_d;
    end
  end
endmodule

// ----- sv/drum_step_sequencer.sv -----
`timescale 1ns / 1ps
// An ignored or rejected word goes from the input buffer straight to its result. A tick reads one
// pattern row per sound, then runs the merge check and, when due, reads every queued hit and writes
// each one that fits and is not yet set; a row clear reads and writes each bar in turn.
// Throughput: one word at a time; the next word starts the cycle after the result is taken.
// Reset is asynchronous and active low; pattern rows read as zero until written.
module drum_step_sequencer #(
  parameter int SOUNDS = 16,
  parameter int BARS = 8,
  parameter int STEPS = 64,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,  // kind
  input  logic [15:0] s_axis_tdata,  // sound, bar_sel, step_sel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // trigger_mask, played_bar, played_step, changed, status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  logic play_q, rec_q; logic [3:0] bars_q; logic [6:0] steps_q, merge_q;
  dss_pkg::cmd_t cmd_in, cmd;
  dss_pkg::res_t res;
  logic cv, cr;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q <= 1'b0; rec_q <= 1'b0; bars_q <= 4'd2; steps_q <= 7'd16; merge_q <= 7'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dss_pkg::REG_PLAY:  play_q <= cfg_data_i[0];
        dss_pkg::REG_REC:   rec_q <= cfg_data_i[0];
        dss_pkg::REG_BARS:  bars_q <= cfg_data_i[3:0];
        dss_pkg::REG_STEPS: steps_q <= cfg_data_i;
        dss_pkg::REG_MERGE: merge_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cmd_in.kind = s_axis_tuser;
  assign cmd_in.sound = s_axis_tdata[3:0];
  assign cmd_in.bar_sel = s_axis_tdata[6:4];
  assign cmd_in.step_sel = s_axis_tdata[12:7];

  dss_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_cmd_i(cmd_in), .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_o(cmd));

  dss_back #(.Sounds(SOUNDS), .Bars(BARS), .Steps(STEPS), .QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_ready_o(cr), .cmd_i(cmd),
    .play_en_i(play_q), .rec_en_i(rec_q), .bar_count_i(bars_q),
    .steps_per_bar_i(steps_q), .merge_interval_i(merge_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res));

  assign m_axis_tdata = {4'b0, res.status, res.changed, res.played_step,
                         res.played_bar, res.trigger_mask};
endmodule

// ----- sv/dss_checker.sv -----
`timescale 1ns / 1ps
`include "drum_step_sequencer_assert.svh"
module dss_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  `DSS_ASSERT_IMPL(a_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `DSS_ASSERT_IMPL(a_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
  `DSS_ASSERT_IMPL(a_idle, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[27:26] != 2'd0 |-> m_axis_tdata[25:0] == 26'd0)
  `DSS_ASSERT_RST(a_rst, clk_i, !rst_ni |=> !m_axis_tvalid)
endmodule

bind drum_step_sequencer dss_port_checker u_chk (.*);

// ----- tb/dss_checker.sv -----
`timescale 1ns / 1ps
module dss_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,  // kind
  input  logic [15:0] s_axis_tdata,  // sound, bar_sel, step_sel
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // trigger_mask, played_bar, played_step, changed, status
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          outstanding_o
);
  localparam int NSOUNDS = 16;
  localparam int NBARS = 8;
  localparam int NSTEPS = 64;
  localparam int QDEPTH = 16;

  logic [63:0] pattern [NBARS][NSOUNDS];
  int          pos_step;
  int          pos_bar;
  logic [3:0]  hit_sound [QDEPTH];
  logic [2:0]  hit_bar [QDEPTH];
  logic [5:0]  hit_step [QDEPTH];
  int          hit_count;
  logic        play_en;
  logic        rec_en;
  logic [3:0]  bar_count;
  logic [6:0]  steps_per_bar;
  logic [6:0]  merge_interval;
  logic [31:0] expected_results [$];
  int          fail_count;

  assign fail_count_o = fail_count;
  assign outstanding_o = expected_results.size();

  function automatic int loop_bars();
    if (bar_count < 1) return 1;
    if (bar_count > NBARS) return NBARS;
    return int'(bar_count);
  endfunction

  function automatic int loop_steps();
    if (steps_per_bar < 1) return 1;
    if (steps_per_bar > NSTEPS) return NSTEPS;
    return int'(steps_per_bar);
  endfunction

  function automatic bit in_loop(int s, int b, int t);
    return s < NSOUNDS && b < loop_bars() && t < loop_steps();
  endfunction

  task automatic merge_hits(output logic changed);
    changed = 1'b0;
    for (int i = 0; i < hit_count; i++) begin
      if (in_loop(hit_sound[i], hit_bar[i], hit_step[i])) begin
        if (!pattern[hit_bar[i]][hit_sound[i]][hit_step[i]]) begin
          pattern[hit_bar[i]][hit_sound[i]][hit_step[i]] = 1'b1;
          changed = 1'b1;
        end
      end
    end
    hit_count = 0;
  endtask

  task automatic predict_sequencer_result(input logic [15:0] word, output logic [31:0] res);
    logic [2:0]  kind;
    int          snd;
    int          bsel;
    int          ssel;
    logic [15:0] mask;
    int          pbar;
    int          pstep;
    logic        changed;
    logic [1:0]  status;
    int          ivl;
    logic [63:0] m;
    kind = word[2:0];
    snd = word[6:3];
    bsel = word[9:7];
    ssel = word[15:10];
    mask = '0;
    pbar = 0;
    pstep = 0;
    changed = 1'b0;
    status = dss_pkg::ST_DONE;
    case (kind)
      dss_pkg::KIND_TICK: begin
        if (!play_en) begin
          status = dss_pkg::ST_IGNORED;
        end else begin
          pbar = pos_bar;
          pstep = pos_step;
          for (int i = 0; i < NSOUNDS; i++) mask[i] = pattern[pos_bar][i][pos_step];
          pos_step++;
          if (pos_step >= loop_steps()) begin
            pos_step = 0;
            pos_bar++;
            if (pos_bar >= loop_bars()) pos_bar = 0;
          end
          ivl = (merge_interval == 0) ? 1 : int'(merge_interval);
          if (pos_step % ivl == 0) merge_hits(changed);
        end
      end
      dss_pkg::KIND_RECORD: begin
        if (!rec_en) begin
          status = dss_pkg::ST_IGNORED;
        end else if (!in_loop(snd, pos_bar, pos_step)) begin
          status = dss_pkg::ST_BAD;
        end else begin
          pattern[pos_bar][snd][pos_step] = 1'b1;
          mask[snd] = 1'b1;
          pbar = pos_bar;
          pstep = pos_step;
        end
      end
      dss_pkg::KIND_DELETE: begin
        if (!in_loop(snd, bsel, ssel)) begin
          status = dss_pkg::ST_BAD;
        end else begin
          changed = pattern[bsel][snd][ssel];
          pattern[bsel][snd][ssel] = 1'b0;
        end
      end
      dss_pkg::KIND_CLEAR: begin
        m = (loop_steps() >= 64) ? '1 : ((64'd1 << loop_steps()) - 64'd1);
        for (int b = 0; b < loop_bars(); b++) begin
          if ((pattern[b][snd] & m) != 0) changed = 1'b1;
          pattern[b][snd] &= ~m;
        end
      end
      dss_pkg::KIND_PENDING: begin
        if (!in_loop(snd, bsel, ssel)) begin
          status = dss_pkg::ST_BAD;
        end else if (hit_count >= QDEPTH) begin
          status = dss_pkg::ST_FULL;
        end else begin
          hit_sound[hit_count] = snd;
          hit_bar[hit_count] = bsel;
          hit_step[hit_count] = ssel;
          hit_count++;
        end
      end
      default: status = dss_pkg::ST_BAD;
    endcase
    res = {4'd0, status, changed, 6'(pstep), 3'(pbar), mask};
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] exp_w;
    if (!rst_ni) begin
      for (int b = 0; b < NBARS; b++)
        for (int s = 0; s < NSOUNDS; s++) pattern[b][s] = '0;
      pos_step = 0;
      pos_bar = 0;
      hit_count = 0;
      play_en = 1'b0;
      rec_en = 1'b0;
      bar_count = 4'd2;
      steps_per_bar = 7'd16;
      merge_interval = 7'd16;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          exp_w = expected_results.pop_front();
          check_field("trigger_mask", exp_w[15:0], m_axis_tdata[15:0]);
          check_field("played_bar", exp_w[18:16], m_axis_tdata[18:16]);
          check_field("played_step", exp_w[24:19], m_axis_tdata[24:19]);
          check_field("changed", exp_w[25], m_axis_tdata[25]);
          check_field("status", exp_w[27:26], m_axis_tdata[27:26]);
          check_field("padding", 0, m_axis_tdata[31:28]);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          dss_pkg::REG_PLAY:  play_en = cfg_data_i[0];
          dss_pkg::REG_REC:   rec_en = cfg_data_i[0];
          dss_pkg::REG_BARS:  bar_count = cfg_data_i[3:0];
          dss_pkg::REG_STEPS: steps_per_bar = cfg_data_i;
          dss_pkg::REG_MERGE: merge_interval = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sequencer_result({s_axis_tdata[12:0], s_axis_tuser}, exp_w);
        expected_results.push_back(exp_w);
      end
    end
  end
endmodule

// ----- tb/tb_drum_step_sequencer.sv -----
`timescale 1ns / 1ps
module tb_drum_step_sequencer;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 225;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;
  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          steady_mode = 1'b0;
  int          cur_bars = 2;
  int          cur_steps = 16;

  always #6 clk_i = ~clk_i;

  drum_step_sequencer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  dss_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    int draw;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        draw = steady_mode ? 0 : $urandom_range(0, 10);
        stall_left <= draw;
        if (draw > 0) m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        if (stall_left == 1) m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pack_word(logic [2:0] kind, int snd, int bsel, int ssel);
    return {6'(ssel), 3'(bsel), 4'(snd), kind};
  endfunction

  task automatic send_word(logic [15:0] word);
    int  gap;
    bit  ok;
    gap = steady_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= word[2:0];
    s_axis_tdata <= {3'b0, word[15:3]};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] value);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    if (idx == dss_pkg::REG_BARS)
      cur_bars = (value[3:0] < 1) ? 1 : (value[3:0] > 8) ? 8 : value[3:0];
    if (idx == dss_pkg::REG_STEPS) cur_steps = (value < 1) ? 1 : (value > 64) ? 64 : value;
  endtask

  task automatic set_mode(bit pe, bit re, logic [6:0] bars, logic [6:0] steps,
                          logic [6:0] merge);
    write_reg(dss_pkg::REG_PLAY, {6'($urandom_range(0, 63)), pe});
    write_reg(dss_pkg::REG_REC, {6'($urandom_range(0, 63)), re});
    write_reg(dss_pkg::REG_BARS, bars);
    write_reg(dss_pkg::REG_STEPS, steps);
    write_reg(dss_pkg::REG_MERGE, merge);
  endtask

  function automatic logic [15:0] random_word();
    int          pick;
    logic [2:0]  kind;
    int          bsel;
    int          ssel;
    pick = $urandom_range(0, 99);
    if (pick < 40)      kind = dss_pkg::KIND_TICK;
    else if (pick < 58) kind = dss_pkg::KIND_RECORD;
    else if (pick < 68) kind = dss_pkg::KIND_DELETE;
    else if (pick < 73) kind = dss_pkg::KIND_CLEAR;
    else if (pick < 95) kind = dss_pkg::KIND_PENDING;
    else                kind = 3'($urandom_range(5, 7));
    bsel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, cur_bars - 1);
    ssel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, cur_steps - 1);
    return pack_word(kind, $urandom_range(0, 15), bsel, ssel);
  endfunction

  initial begin
    logic [6:0] modes [8][3];
    bit         ens [8][2];
    modes = '{'{7'd2, 7'd16, 7'd16}, '{7'd1, 7'd1, 7'd1}, '{7'd8, 7'd64, 7'd64},
              '{7'd0, 7'd0, 7'd0}, '{7'd15, 7'd127, 7'd127}, '{7'd3, 7'd5, 7'd3},
              '{7'd4, 7'd8, 7'd2}, '{7'd6, 7'd12, 7'd5}};
    ens = '{'{1, 1}, '{1, 1}, '{1, 1}, '{1, 1}, '{1, 1}, '{1, 0}, '{0, 1}, '{1, 1}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(pack_word(dss_pkg::KIND_TICK, 0, 0, 0));
    send_word(pack_word(dss_pkg::KIND_RECORD, 3, 0, 0));
    for (int k = 5; k < 8; k++) send_word(pack_word(3'(k), 15, 7, 63));
    send_word(pack_word(dss_pkg::KIND_DELETE, 2, 2, 3));
    send_word(pack_word(dss_pkg::KIND_PENDING, 2, 1, 16));
    send_word(pack_word(dss_pkg::KIND_CLEAR, 15, 0, 0));
    for (int i = 0; i < 17; i++)
      send_word(pack_word(dss_pkg::KIND_PENDING, i % 16, i % 2, 15 - (i % 16)));
    drain();
    set_mode(1'b1, 1'b1, 7'd2, 7'd16, 7'd16);
    send_word(pack_word(dss_pkg::KIND_RECORD, 15, 0, 0));
    send_word(pack_word(dss_pkg::KIND_DELETE, 0, 1, 15));
    drain();

    for (int p = 0; p < 8; p++) begin
      set_mode(ens[p][0], ens[p][1], modes[p][0], modes[p][1], modes[p][2]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) steady_mode = ($urandom_range(0, 3) == 0);
        send_word(random_word());
      end
      steady_mode = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
